/* rtl/core/barometric_pressure_compensation_core_defines.svh */
// assertion macros shared by the pressure compensation rtl
// no dependencies; taken in by files that carry concurrent checks
`ifndef BAROMETRIC_PRESSURE_COMPENSATION_CORE_DEFINES_SVH
`define BAROMETRIC_PRESSURE_COMPENSATION_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define BPC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bpc check failed");

// next-cycle implication, disabled while reset is asserted
`define BPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bpc check failed");

`endif

/* rtl/core/bpc_pkg.sv */
// shared types, widths, codes and helpers for the pressure compensation core
// no dependencies; imported by every module of the block
package bpc_pkg;

	// field widths
	localparam int RAW_W  = 24;
	localparam int COEF_W = 16;
	localparam int PRES_W = 17;
	localparam int TOUT_W = 15;
	localparam int CFG_IDX_W = 3;

	// internal widths
	localparam int DT_W    = 25;  // d2 - c5*2^8
	localparam int MUL_W   = 42;  // dt times a coefficient
	localparam int DTSQ_W  = 50;  // dt squared
	localparam int TQ_W    = 18;  // dt*c6/2^23
	localparam int OQ_W    = 34;  // c4*dt/2^7
	localparam int SQ_W    = 33;  // c3*dt/2^8
	localparam int T2_W    = 17;
	localparam int T2_LSB  = 31;
	localparam int TEMP0_W = 19;  // first order temperature
	localparam int OFF0_W  = 35;
	localparam int SENS0_W = 34;
	localparam int AB_W    = 18;  // temperature deltas for second order
	localparam int SQR_W   = 34;  // squared deltas
	localparam int CORR_W  = 38;  // off2, sens2
	localparam int TEMP_W  = 20;  // final temperature before clamp
	localparam int OFFS_W  = 40;  // final off and sens
	localparam int SPLIT   = 19;  // low part of sens for the split multiply
	localparam int PHI_W   = DT_W + OFFS_W - SPLIT;
	localparam int PLO_W   = RAW_W + SPLIT;
	localparam int WIDE_W  = 64;
	localparam int Q_W     = 43;
	localparam int R_W     = 44;
	localparam int P_W     = 30;

	// scaling shifts
	localparam int SH_TEMP = 23;
	localparam int SH_OFF  = 7;
	localparam int SH_SENS = 8;
	localparam int SH_PQ   = 21;
	localparam int SH_P    = 15;

	// reference points
	localparam logic signed [TEMP0_W-1:0] TEMP_REF  = 19'sd2000;
	localparam logic signed [AB_W-1:0]    COLD_LIM  = -18'sd3500;  // -15.00 C less 20.00 C
	localparam logic signed [AB_W-1:0]    COLD_BIAS = 18'sd3500;

	// output limits
	localparam int P_MIN = 1000;
	localparam int P_MAX = 120000;
	localparam int T_MIN = -4000;
	localparam int T_MAX = 8500;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_ZERO = 2'd1,
		ST_SAT  = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SENS        = 3'd0,
		REG_OFFSET      = 3'd1,
		REG_SENS_TEMP   = 3'd2,
		REG_OFFSET_TEMP = 3'd3,
		REG_REF_TEMP    = 3'd4,
		REG_TEMP_SLOPE  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [COEF_W-1:0] sens;
		logic [COEF_W-1:0] offset;
		logic [COEF_W-1:0] sens_temp;
		logic [COEF_W-1:0] offset_temp;
		logic [COEF_W-1:0] ref_temp;
		logic [COEF_W-1:0] temp_slope;
	} coef_t;

	typedef struct packed {
		logic [RAW_W-1:0] raw_pressure;
		logic [RAW_W-1:0] raw_temperature;
	} in_t;

	// first order results
	typedef struct packed {
		logic [RAW_W-1:0]          d1;
		logic                      zero;
		logic signed [TEMP0_W-1:0] temp;
		logic signed [OFF0_W-1:0]  off;
		logic signed [SENS0_W-1:0] sens;
		logic [T2_W-1:0]           t2;
		logic signed [AB_W-1:0]    a;
		logic signed [AB_W-1:0]    b;
	} base_t;

	// second order corrected values
	typedef struct packed {
		logic [RAW_W-1:0]         d1;
		logic                     zero;
		logic signed [TEMP_W-1:0] temp;
		logic signed [OFFS_W-1:0] off;
		logic signed [OFFS_W-1:0] sens;
	} corr_t;

	typedef struct packed {
		logic [PRES_W-1:0]        pressure;
		logic signed [TOUT_W-1:0] temperature;
		status_t                  status;
	} res_t;

	// signed shift right that rounds toward zero
	function automatic logic signed [WIDE_W-1:0] trunc_shr(input logic signed [WIDE_W-1:0] x,
		input int unsigned sh);
		logic signed [WIDE_W-1:0] bias;
		bias = x[WIDE_W-1] ? ((64'sd1 <<< sh) - 64'sd1) : 64'sd0;
		return (x + bias) >>> sh;
	endfunction

endpackage

/* rtl/core/bpc_base_stage.sv */
// stages 1 to 4: dt, the coefficient products and the first order terms
// depends on bpc_pkg
module bpc_base_stage import bpc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  coef_t coef,
	input  logic  in_valid,
	output logic  in_ready,
	input  in_t   in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output base_t out_data
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	// a stage loads when empty or when the next one moves
	assign en_s4    = !v_s4 || out_ready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;
	assign out_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	logic [RAW_W-1:0]          d1_s1, d1_s2, d1_s3;
	logic                      zero_s1, zero_s2, zero_s3;
	logic signed [DT_W-1:0]    dt_s1;
	logic signed [MUL_W-1:0]   dtc6_s2, dtc4_s2, dtc3_s2;
	logic signed [DTSQ_W-1:0]  dtsq_s2;
	logic signed [TQ_W-1:0]    tq_s3;
	logic signed [OQ_W-1:0]    oq_s3;
	logic signed [SQ_W-1:0]    sq_s3;
	logic [T2_W-1:0]           t2_s3;
	logic signed [WIDE_W-1:0]  tq_full, oq_full, sq_full;
	logic                      tneg, tcold;

	always_comb begin
		tq_full = trunc_shr(WIDE_W'(dtc6_s2), SH_TEMP);
		oq_full = trunc_shr(WIDE_W'(dtc4_s2), SH_OFF);
		sq_full = trunc_shr(WIDE_W'(dtc3_s2), SH_SENS);
	end

	// below 20.00 C and below -15.00 C, seen on the temperature delta
	assign tneg  = tq_s3[TQ_W-1];
	assign tcold = tq_s3 < COLD_LIM;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			d1_s1   <= in_data.raw_pressure;
			zero_s1 <= (in_data.raw_pressure == '0) || (in_data.raw_temperature == '0);
			dt_s1   <= $signed({1'b0, in_data.raw_temperature})
				- $signed({1'b0, coef.ref_temp, 8'h00});
		end
		if (en_s2) begin
			d1_s2   <= d1_s1;
			zero_s2 <= zero_s1;
			dtc6_s2 <= MUL_W'(dt_s1) * MUL_W'($signed({1'b0, coef.temp_slope}));
			dtc4_s2 <= MUL_W'(dt_s1) * MUL_W'($signed({1'b0, coef.offset_temp}));
			dtc3_s2 <= MUL_W'(dt_s1) * MUL_W'($signed({1'b0, coef.sens_temp}));
			dtsq_s2 <= DTSQ_W'(dt_s1) * DTSQ_W'(dt_s1);
		end
		if (en_s3) begin
			d1_s3   <= d1_s2;
			zero_s3 <= zero_s2;
			tq_s3   <= tq_full[TQ_W-1:0];
			oq_s3   <= oq_full[OQ_W-1:0];
			sq_s3   <= sq_full[SQ_W-1:0];
			t2_s3   <= dtsq_s2[T2_LSB +: T2_W];
		end
		if (en_s4) begin
			out_data.d1   <= d1_s3;
			out_data.zero <= zero_s3;
			out_data.temp <= TEMP_REF + TEMP0_W'(tq_s3);
			out_data.off  <= $signed({3'b000, coef.offset, 16'h0000}) + OFF0_W'(oq_s3);
			out_data.sens <= $signed({3'b000, coef.sens, 15'h0000}) + SENS0_W'(sq_s3);
			out_data.t2   <= tneg ? t2_s3 : '0;
			out_data.a    <= tneg ? tq_s3 : '0;
			out_data.b    <= tcold ? (tq_s3 + COLD_BIAS) : '0;
		end
	end

endmodule

/* rtl/core/bpc_corr_stage.sv */
// stages 5 to 7: second order correction of temp, off and sens
// depends on bpc_pkg
module bpc_corr_stage import bpc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  base_t in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output corr_t out_data
);

	logic v_s5, v_s6, v_s7;
	logic en_s5, en_s6, en_s7;

	assign en_s7     = !v_s7 || out_ready;
	assign en_s6     = !v_s6 || en_s7;
	assign en_s5     = !v_s5 || en_s6;
	assign in_ready  = en_s5;
	assign out_valid = v_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en_s5) v_s5 <= in_valid;
			if (en_s6) v_s6 <= v_s5;
			if (en_s7) v_s7 <= v_s6;
		end
	end

	logic [RAW_W-1:0]           d1_s5, d1_s6;
	logic                       zero_s5, zero_s6;
	logic signed [TEMP0_W-1:0]  temp_s5;
	logic signed [TEMP_W-1:0]   temp_s6;
	logic signed [OFF0_W-1:0]   off_s5, off_s6;
	logic signed [SENS0_W-1:0]  sens_s5, sens_s6;
	logic [T2_W-1:0]            t2_s5;
	logic [SQR_W-1:0]           a2_s5, b2_s5;
	logic [CORR_W-1:0]          off2_s6, sens2_s6;
	logic signed [2*AB_W-1:0]   a2_full, b2_full;
	logic [SQR_W+2:0]           a5, b7;
	logic [SQR_W+3:0]           b11;
	logic [CORR_W-1:0]          off2_c, sens2_c;

	// deltas are zero where no correction applies, so the squares vanish
	always_comb begin
		a2_full = (2*AB_W)'(in_data.a) * (2*AB_W)'(in_data.a);
		b2_full = (2*AB_W)'(in_data.b) * (2*AB_W)'(in_data.b);
	end

	// constant multiples by shift and add; all terms are non-negative
	always_comb begin
		a5  = {1'b0, a2_s5, 2'b00} + {3'b000, a2_s5};
		b7  = {b2_s5, 3'b000} - {3'b000, b2_s5};
		b11 = {1'b0, b2_s5, 3'b000} + {3'b000, b2_s5, 1'b0} + {4'b0000, b2_s5};
		off2_c  = {2'b00, a5[SQR_W+2:1]} + {1'b0, b7};
		sens2_c = {3'b000, a5[SQR_W+2:2]} + {1'b0, b11[SQR_W+3:1]};
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			d1_s5   <= in_data.d1;
			zero_s5 <= in_data.zero;
			temp_s5 <= in_data.temp;
			off_s5  <= in_data.off;
			sens_s5 <= in_data.sens;
			t2_s5   <= in_data.t2;
			a2_s5   <= a2_full[SQR_W-1:0];
			b2_s5   <= b2_full[SQR_W-1:0];
		end
		if (en_s6) begin
			d1_s6    <= d1_s5;
			zero_s6  <= zero_s5;
			temp_s6  <= TEMP_W'(temp_s5) - $signed({3'b000, t2_s5});
			off_s6   <= off_s5;
			sens_s6  <= sens_s5;
			off2_s6  <= off2_c;
			sens2_s6 <= sens2_c;
		end
		if (en_s7) begin
			out_data.d1   <= d1_s6;
			out_data.zero <= zero_s6;
			out_data.temp <= temp_s6;
			out_data.off  <= OFFS_W'(off_s6) - $signed({2'b00, off2_s6});
			out_data.sens <= OFFS_W'(sens_s6) - $signed({2'b00, sens2_s6});
		end
	end

endmodule

/* rtl/core/bpc_press_stage.sv */
// stages 8 to 13: split d1*sens product, pressure scaling, clamp and status
// depends on bpc_pkg
module bpc_press_stage import bpc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  corr_t in_data,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  out_data
);

	logic v_s8, v_s9, v_s10, v_s11, v_s12, v_s13;
	logic en_s8, en_s9, en_s10, en_s11, en_s12, en_s13;

	assign en_s13    = !v_s13 || out_ready;
	assign en_s12    = !v_s12 || en_s13;
	assign en_s11    = !v_s11 || en_s12;
	assign en_s10    = !v_s10 || en_s11;
	assign en_s9     = !v_s9 || en_s10;
	assign en_s8     = !v_s8 || en_s9;
	assign in_ready  = en_s8;
	assign out_valid = v_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			v_s12 <= 1'b0;
			v_s13 <= 1'b0;
		end else begin
			if (en_s8)  v_s8  <= in_valid;
			if (en_s9)  v_s9  <= v_s8;
			if (en_s10) v_s10 <= v_s9;
			if (en_s11) v_s11 <= v_s10;
			if (en_s12) v_s12 <= v_s11;
			if (en_s13) v_s13 <= v_s12;
		end
	end

	logic                      zero_s8, zero_s9, zero_s10, zero_s11, zero_s12;
	logic signed [TEMP_W-1:0]  temp_s8, temp_s9, temp_s10, temp_s11, temp_s12;
	logic signed [OFFS_W-1:0]  off_s8, off_s9, off_s10;
	logic signed [PHI_W-1:0]   phi_s8;
	logic [PLO_W-1:0]          plo_s8;
	logic signed [WIDE_W-1:0]  prod_s9;
	logic signed [Q_W-1:0]     q_s10;
	logic signed [R_W-1:0]     r_s11;
	logic signed [P_W-1:0]     p_s12;
	logic signed [WIDE_W-1:0]  q_full, p_full;
	logic [PRES_W-1:0]         pres_c;
	logic signed [TOUT_W-1:0]  tout_c;
	logic                      sat_c;
	status_t                   st_c;

	always_comb begin
		q_full = trunc_shr(prod_s9, SH_PQ);
		p_full = trunc_shr(WIDE_W'(r_s11), SH_P);
	end

	// clamp both results; a zero reading overrides everything
	always_comb begin
		sat_c  = 1'b0;
		pres_c = p_s12[PRES_W-1:0];
		tout_c = temp_s12[TOUT_W-1:0];
		if (p_s12 < P_W'(P_MIN)) begin
			pres_c = PRES_W'(P_MIN);
			sat_c  = 1'b1;
		end else if (p_s12 > P_W'(P_MAX)) begin
			pres_c = PRES_W'(P_MAX);
			sat_c  = 1'b1;
		end
		if (temp_s12 < TEMP_W'(T_MIN)) begin
			tout_c = TOUT_W'(T_MIN);
			sat_c  = 1'b1;
		end else if (temp_s12 > TEMP_W'(T_MAX)) begin
			tout_c = TOUT_W'(T_MAX);
			sat_c  = 1'b1;
		end
		st_c = sat_c ? ST_SAT : ST_OK;
		if (zero_s12) begin
			pres_c = '0;
			tout_c = '0;
			st_c   = ST_ZERO;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s8) begin
			zero_s8 <= in_data.zero;
			temp_s8 <= in_data.temp;
			off_s8  <= in_data.off;
			phi_s8  <= PHI_W'($signed({1'b0, in_data.d1}))
				* PHI_W'($signed(in_data.sens[OFFS_W-1:SPLIT]));
			plo_s8  <= PLO_W'(in_data.d1) * PLO_W'(in_data.sens[SPLIT-1:0]);
		end
		if (en_s9) begin
			zero_s9 <= zero_s8;
			temp_s9 <= temp_s8;
			off_s9  <= off_s8;
			prod_s9 <= (WIDE_W'(phi_s8) <<< SPLIT) + $signed({{(WIDE_W-PLO_W){1'b0}}, plo_s8});
		end
		if (en_s10) begin
			zero_s10 <= zero_s9;
			temp_s10 <= temp_s9;
			off_s10  <= off_s9;
			q_s10    <= q_full[Q_W-1:0];
		end
		if (en_s11) begin
			zero_s11 <= zero_s10;
			temp_s11 <= temp_s10;
			r_s11    <= R_W'(q_s10) - R_W'(off_s10);
		end
		if (en_s12) begin
			zero_s12 <= zero_s11;
			temp_s12 <= temp_s11;
			p_s12    <= p_full[P_W-1:0];
		end
		if (en_s13) begin
			out_data.pressure    <= pres_c;
			out_data.temperature <= tout_c;
			out_data.status      <= st_c;
		end
	end

endmodule

/* rtl/core/barometric_pressure_compensation_core.sv */
// top level of the barometer compensation core: register file, three pipeline sections
// depends on bpc_pkg, bpc_base_stage, bpc_corr_stage, bpc_press_stage and the defines header
// The core turns one raw pressure/temperature pair (D1, D2) into compensated pressure in
// hundredths of a millibar and temperature in hundredths of a degree C, using the six
// calibration coefficients written through the cfg port (index 0..5, other indexes are
// ignored). It is a 13-stage pipeline with no feedback: it takes one pair per clock
// while the output is not stalled. Each stage holds a valid bit and loads whenever it
// is empty or its successor moves, so a stall on the output fills bubbles before it
// holds off the input; s_axis_tready drops only when all stages are full and the output
// is not being taken. The widest product, d1 times sens, is split into two partial
// products over two stages. A zero raw reading gives status 1 with zero fields; a
// clamped result gives status 2. Coefficients may only be changed while the pipeline
// is empty.
`include "barometric_pressure_compensation_core_defines.svh"

module barometric_pressure_compensation_core import bpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// coefficient writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_data,
	// raw readings
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [47:0]          s_axis_tdata,   // [23:0] raw_pressure, [47:24] raw_temperature
	// compensated results
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [31:0]          m_axis_tdata,   // [16:0] pressure, [31:17] temperature
	output logic [1:0]           m_axis_tuser    // [1:0] status
);

	coef_t coef_q;
	in_t   in_item;
	base_t base_item;
	corr_t corr_item;
	res_t  res_item;
	logic  base_valid, base_ready;
	logic  corr_valid, corr_ready;

	// coefficient registers; writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SENS:        coef_q.sens        <= cfg_data;
				REG_OFFSET:      coef_q.offset      <= cfg_data;
				REG_SENS_TEMP:   coef_q.sens_temp   <= cfg_data;
				REG_OFFSET_TEMP: coef_q.offset_temp <= cfg_data;
				REG_REF_TEMP:    coef_q.ref_temp    <= cfg_data;
				REG_TEMP_SLOPE:  coef_q.temp_slope  <= cfg_data;
				default: ;  // unknown index, write dropped
			endcase
		end
	end

	// unpack the input transfer
	assign in_item.raw_pressure    = s_axis_tdata[RAW_W-1:0];
	assign in_item.raw_temperature = s_axis_tdata[2*RAW_W-1:RAW_W];

	// dt, coefficient products, first order temp, off and sens
	bpc_base_stage u_base (
		.clk       (clk),
		.arst_n    (arst_n),
		.coef      (coef_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (in_item),
		.out_valid (base_valid),
		.out_ready (base_ready),
		.out_data  (base_item)
	);

	// second order correction below 20.00 C and -15.00 C
	bpc_corr_stage u_corr (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (base_valid),
		.in_ready  (base_ready),
		.in_data   (base_item),
		.out_valid (corr_valid),
		.out_ready (corr_ready),
		.out_data  (corr_item)
	);

	// pressure formula, clamping, status; last stage is the output register
	bpc_press_stage u_press (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (corr_valid),
		.in_ready  (corr_ready),
		.in_data   (corr_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (res_item)
	);

	// pack the output transfer
	assign m_axis_tdata = {res_item.temperature, res_item.pressure};
	assign m_axis_tuser = res_item.status;

	// a zero reading carries zero fields
	`BPC_ASSERT_NOW(a_zero_fields, clk, arst_n, m_axis_tvalid && (m_axis_tuser == ST_ZERO), m_axis_tdata == '0)

	// an unflagged result lies inside both output ranges
	`BPC_ASSERT_NOW(a_ok_in_range, clk, arst_n, m_axis_tvalid && (m_axis_tuser == ST_OK), (m_axis_tdata[16:0] >= 17'(P_MIN)) && (m_axis_tdata[16:0] <= 17'(P_MAX)) && ($signed(m_axis_tdata[31:17]) >= 15'(T_MIN)) && ($signed(m_axis_tdata[31:17]) <= 15'(T_MAX)))

	// input is held off only when the pipeline is full behind a stalled output
	`BPC_ASSERT_NOW(a_backpressure_full, clk, arst_n, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

endmodule

/* dv/compensation_checker.sv */
`timescale 1ns / 1ps
// watches the coefficient, reading and result channels of the pressure compensation core
// predicts each compensated result and compares it field by field; depends on bpc_pkg
module compensation_checker import bpc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_data,
	input  logic                 s_axis_tvalid,
	input  logic                 s_axis_tready,
	input  logic [47:0]          s_axis_tdata,   // [23:0] raw_pressure, [47:24] raw_temperature
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [31:0]          m_axis_tdata,   // [16:0] pressure, [31:17] temperature
	input  logic [1:0]           m_axis_tuser,   // [1:0] status
	output int                   fail_count,
	output int                   pending
);

	localparam int     NUM_COEFS  = 6;
	localparam longint DIV_TEMP   = 64'sd8388608;
	localparam longint DIV_OFF    = 64'sd128;
	localparam longint DIV_SENS   = 64'sd256;
	localparam longint DIV_T2     = 64'sd2147483648;
	localparam longint DIV_PQ     = 64'sd2097152;
	localparam longint DIV_P      = 64'sd32768;
	localparam longint MUL_REF    = 64'sd256;
	localparam longint MUL_OFF    = 64'sd65536;
	localparam longint MUL_SENS   = 64'sd32768;
	localparam longint TEMP_BASE  = 64'sd2000;
	localparam longint COLD_POINT = 64'sd1500;

	typedef struct {
		logic [RAW_W-1:0] d1;
		logic [RAW_W-1:0] d2;
		res_t             want;
	} awaited_t;

	longint   cal [NUM_COEFS];
	awaited_t awaited_results [$];
	int       fails;

	// second order compensation of one raw pair under the current coefficients
	function automatic res_t compensate(input logic [RAW_W-1:0] d1_raw,
		input logic [RAW_W-1:0] d2_raw);
		longint d1, d2, dt, t, off, sens, t2, off2, sens2, p, a, b;
		logic   sat;
		res_t   r;
		d1 = longint'(d1_raw);
		d2 = longint'(d2_raw);
		if (d1 == 0 || d2 == 0) begin
			r.pressure    = '0;
			r.temperature = '0;
			r.status      = ST_ZERO;
			return r;
		end
		t2    = 0;
		off2  = 0;
		sens2 = 0;
		sat   = 1'b0;
		dt   = d2 - cal[REG_REF_TEMP] * MUL_REF;
		t    = TEMP_BASE + (dt * cal[REG_TEMP_SLOPE]) / DIV_TEMP;
		off  = cal[REG_OFFSET] * MUL_OFF + (cal[REG_OFFSET_TEMP] * dt) / DIV_OFF;
		sens = cal[REG_SENS] * MUL_SENS + (cal[REG_SENS_TEMP] * dt) / DIV_SENS;
		// cold side: below 20 C, with an extra term below -15 C
		if (t < TEMP_BASE) begin
			a     = t - TEMP_BASE;
			t2    = (dt * dt) / DIV_T2;
			off2  = 5 * a * a / 2;
			sens2 = 5 * a * a / 4;
			if (t < -COLD_POINT) begin
				b     = t + COLD_POINT;
				off2  = off2 + 7 * b * b;
				sens2 = sens2 + 11 * b * b / 2;
			end
		end
		t    = t - t2;
		off  = off - off2;
		sens = sens - sens2;
		p = ((d1 * sens) / DIV_PQ - off) / DIV_P;
		if (p < P_MIN) begin
			p   = longint'(P_MIN);
			sat = 1'b1;
		end else if (p > P_MAX) begin
			p   = longint'(P_MAX);
			sat = 1'b1;
		end
		if (t < T_MIN) begin
			t   = longint'(T_MIN);
			sat = 1'b1;
		end else if (t > T_MAX) begin
			t   = longint'(T_MAX);
			sat = 1'b1;
		end
		r.pressure    = p[PRES_W-1:0];
		r.temperature = t[TOUT_W-1:0];
		r.status      = sat ? ST_SAT : ST_OK;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		awaited_t fresh;
		awaited_t head;
		res_t     got;
		if (!arst_n) begin
			foreach (cal[i])
				cal[i] = 0;
			awaited_results.delete();
			fails = 0;
			pending    <= 0;
			fail_count <= 0;
		end else begin
			// out of range indexes are dropped by the core
			if (cfg_valid && cfg_ready && cfg_index <= REG_TEMP_SLOPE)
				cal[cfg_index] = longint'(cfg_data);
			if (m_axis_tvalid && m_axis_tready) begin
				got.pressure    = m_axis_tdata[PRES_W-1:0];
				got.temperature = m_axis_tdata[PRES_W +: TOUT_W];
				got.status      = status_t'(m_axis_tuser);
				if (awaited_results.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%t: result p=%0d t=%0d st=%0d with nothing awaited", $realtime,
							got.pressure, $signed(got.temperature), got.status);
				end else begin
					head = awaited_results.pop_front();
					if (got.pressure !== head.want.pressure ||
						got.temperature !== head.want.temperature ||
						got.status !== head.want.status) begin
						fails++;
						if (fails <= 10)
							$display("%t: d1=%0d d2=%0d expected p=%0d t=%0d st=%0d, got p=%0d t=%0d st=%0d",
								$realtime, head.d1, head.d2, head.want.pressure,
								$signed(head.want.temperature), head.want.status,
								got.pressure, $signed(got.temperature), got.status);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				fresh.d1   = s_axis_tdata[RAW_W-1:0];
				fresh.d2   = s_axis_tdata[RAW_W +: RAW_W];
				fresh.want = compensate(fresh.d1, fresh.d2);
				awaited_results.push_back(fresh);
			end
			pending    <= awaited_results.size();
			fail_count <= fails;
		end
	end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// top of the pressure compensation testbench: clock, reset, coefficient and reading stimulus
// depends on bpc_pkg, the core and compensation_checker, which does all the checking
module testbench;
	import bpc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
	localparam int RAW_MAX      = 24'hFFFFFF;
	localparam int PHASE_ITEMS  = 128;
	localparam int NUM_PHASES   = 7;
	localparam int STEADY_PHASE = 3;

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 cfg_valid     = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [COEF_W-1:0]    cfg_data      = '0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [47:0]          s_axis_tdata  = '0;   // [23:0] raw_pressure, [47:24] raw_temperature
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [31:0]          m_axis_tdata;         // [16:0] pressure, [31:17] temperature
	logic [1:0]           m_axis_tuser;         // [1:0] status

	int fail_count;
	int pending;

	// coefficient set the current phase runs under, also used to aim the raw temperature
	logic [COEF_W-1:0] cal_set [6];
	// while set, neither side inserts gaps
	logic              steady = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	barometric_pressure_compensation_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	compensation_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// result side stalls about one cycle in nine unless the phase runs steady
	always @(posedge clk) begin
		m_axis_tready <= steady || ($urandom_range(99) >= 11);
	end

	// one reading transfer; tvalid stays high afterwards so back to back pairs need no bubble
	task automatic send_reading(input logic [RAW_W-1:0] d1, input logic [RAW_W-1:0] d2);
		while (!steady && $urandom_range(99) < 11) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {d2, d1};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// mostly plausible readings around the reference temperature, some raw noise and zeros
	task automatic send_random_reading();
		longint d1, d2;
		case ($urandom_range(19))
			0, 1: begin
				d1 = longint'($urandom_range(RAW_MAX));
				d2 = longint'($urandom_range(RAW_MAX));
			end
			2: begin
				d1 = $urandom_range(1) ? 64'sd0 : longint'($urandom_range(RAW_MAX));
				d2 = (d1 != 0 || $urandom_range(1)) ? 64'sd0 : longint'($urandom_range(RAW_MAX));
			end
			default: begin
				d1 = longint'($urandom_range(12_000_000, 4_000_000));
				d2 = longint'(cal_set[REG_REF_TEMP]) * 256
					+ longint'($urandom_range(8_000_000)) - 4_000_000;
				if (d2 < 1)
					d2 = 64'sd1;
				if (d2 > RAW_MAX)
					d2 = longint'(RAW_MAX);
			end
		endcase
		send_reading(d1[RAW_W-1:0], d2[RAW_W-1:0]);
	endtask

	// write all six coefficients plus one out of range index, then release the channel
	task automatic load_coefs();
		for (int i = 0; i < 6; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= reg_idx_t'(i);
			cfg_data  <= cal_set[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b1;
		cfg_index <= $urandom_range(1) ? REG_UNUSED_LO : REG_UNUSED_HI;
		cfg_data  <= COEF_W'($urandom_range(16'hFFFF));
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// wait until the registered pending count has taken in the last transfer and emptied, then let the pipe settle
	task automatic drain();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic pick_setting(input int phase);
		case (phase)
			0, 3: cal_set = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
			1: cal_set = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
			2: cal_set = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
			4: cal_set = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000};
			5: cal_set = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF};
			default: begin
				foreach (cal_set[i])
					cal_set[i] = COEF_W'($urandom_range(16'hFFFF));
			end
		endcase
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pairs under a typical calibration
		pick_setting(0);
		load_coefs();
		send_reading(24'd0, 24'd8569150);          // zero pressure reading
		send_reading(24'd9085466, 24'd0);          // zero temperature reading
		send_reading(24'd0, 24'd0);
		send_reading(24'd9085466, 24'd8569150);    // warm, first order only
		send_reading(24'd9085466, 24'd8566784);    // exactly 20 C, no correction
		send_reading(24'd9085466, 24'd8566783);    // one count below the reference, still 20.00 C
		send_reading(24'd9085466, 24'd8400000);    // cool, second order
		send_reading(24'd9085466, 24'd7529770);    // around the -15 C threshold
		send_reading(24'd9085466, 24'd7529775);
		send_reading(24'd9085466, 24'd7529790);
		send_reading(24'd9085466, 24'd6566784);    // very cold, extra term
		send_reading(24'hFFFFFF, 24'hFFFFFF);      // hot, temperature clamps high
		send_reading(24'd1, 24'd1);                // cold, temperature clamps low
		send_reading(24'd1, 24'd8569150);          // pressure clamps low
		send_reading(24'hFFFFFF, 24'd8569150);     // pressure clamps high
		send_reading(24'hFFFFFF, 24'd1);
		send_reading(24'd1, 24'hFFFFFF);
		send_reading(24'hAAAAAA, 24'h555555);
		send_reading(24'h555555, 24'hAAAAAA);
		s_axis_tvalid <= 1'b0;
		drain();

		// random phases, each under its own calibration
		for (int ph = 1; ph <= NUM_PHASES; ph++) begin
			pick_setting(ph);
			load_coefs();
			steady = (ph == STEADY_PHASE);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_random_reading();
			s_axis_tvalid <= 1'b0;
			steady = 1'b0;
			drain();
		end

		if (fail_count == 0 && pending == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#1_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
